>>> rtl/sbd_pkg.sv
package sbd_pkg;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_CAPACITY  = 2'd2;

  // Character classes beyond the 64 alphabet values.
  localparam logic [6:0] CH_PAD = 7'd64;
  localparam logic [6:0] CH_BAD = 7'd65;

  localparam int unsigned ALPHA_UPPER = 26;
  localparam int unsigned ALPHA_DIGIT = 52;
  localparam logic [6:0] VAL_PLUS  = 7'd62;
  localparam logic [6:0] VAL_SLASH = 7'd63;

  localparam logic [3:0] PAD1_MASK = 4'h3;
  localparam logic [3:0] PAD2_MASK = 4'hf;

  // Decoded bytes of one finished group plus the end-of-message flags.
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      nbytes;
    logic            eom;
    logic [1:0]      status;
    logic [15:0]     length;
  } sbd_bundle_t;

  function automatic logic [6:0] classify(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= "A" && c <= "Z") begin
      d = c - 8'd65;
      return {1'b0, d[5:0]};
    end else if (c >= "a" && c <= "z") begin
      d = c - 8'd97 + 8'(ALPHA_UPPER);
      return {1'b0, d[5:0]};
    end else if (c >= "0" && c <= "9") begin
      d = c - 8'd48 + 8'(ALPHA_DIGIT);
      return {1'b0, d[5:0]};
    end else if (c == "+") begin
      return VAL_PLUS;
    end else if (c == "/") begin
      return VAL_SLASH;
    end else if (c == "=") begin
      return CH_PAD;
    end
    return CH_BAD;
  endfunction

endpackage

>>> rtl/sbd_decode.sv
module sbd_decode
  import sbd_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char,
  input  logic        in_eom,
  input  logic [15:0] capacity,
  output logic        bun_valid,
  input  logic        bun_ready,
  output sbd_bundle_t bun
);

  localparam int CW = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 1;

  logic                   s_valid_r, s_valid_nxt;
  logic [7:0]             s_char_r;
  logic                   s_eom_r;
  logic [17:0]            acc_r, acc_nxt;
  logic [1:0]             pos_r, pos_nxt;
  logic [1:0]             pad_r, pad_nxt;
  logic [1:0]             err_r, err_nxt;
  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt;

  logic [6:0]  cls;
  logic [5:0]  sext;
  logic [23:0] word;
  logic [1:0]  nb;
  logic [1:0]  n;
  logic [CW-1:0] sum, cap_ext, mask_ext, cap_lim, len_ext;
  logic        produce, advance;

  always_comb begin
    cls     = classify(s_char_r);
    sext    = cls[5:0];
    pad_nxt = pad_r;
    err_nxt = err_r;
    cnt_nxt = cnt_r;
    nb      = 2'd0;
    n       = 2'd0;

    if (cls == CH_PAD) begin
      if (pos_r == 2'd2 && pad_r == 2'd0 && !s_eom_r) begin
        pad_nxt = 2'd1;
      end else if (pos_r == 2'd3 && s_eom_r && pad_r < 2'd2) begin
        pad_nxt = pad_r + 2'd1;
      end else begin
        err_nxt = ST_MALFORMED;
      end
      sext = 6'd0;
    end else if (cls == CH_BAD) begin
      err_nxt = ST_MALFORMED;
      sext    = 6'd0;
    end else if (pad_r != 2'd0) begin
      err_nxt = ST_MALFORMED;
    end

    if (s_eom_r) begin
      if (pos_r != 2'd3) err_nxt = ST_MALFORMED;
      if (pad_nxt == 2'd1 && (acc_r[3:0] & PAD1_MASK) != 4'd0) err_nxt = ST_MALFORMED;
      if (pad_nxt == 2'd2 && (acc_r[9:6] & PAD2_MASK) != 4'd0) err_nxt = ST_MALFORMED;
    end

    word = {acc_r, sext};

    // Capacity check against out_capacity clamped to the counter range.
    mask_ext = {{(CW-LENGTH_BITS){1'b0}}, {LENGTH_BITS{1'b1}}};
    cap_ext  = CW'(capacity);
    cap_lim  = (cap_ext > mask_ext) ? mask_ext : cap_ext;
    n        = 2'd3 - ((pad_nxt > 2'd2) ? 2'd2 : pad_nxt);
    sum      = CW'(cnt_r) + CW'(n);

    if (pos_r == 2'd3 && err_nxt == ST_OK) begin
      if (sum > cap_lim) begin
        err_nxt = ST_CAPACITY;
      end else begin
        nb      = n;
        cnt_nxt = sum[LENGTH_BITS-1:0];
      end
    end

    acc_nxt = (pos_r == 2'd3) ? 18'd0 : word[17:0];
    pos_nxt = pos_r + 2'd1;

    len_ext     = CW'(cnt_nxt);
    bun.data[0] = word[23:16];
    bun.data[1] = word[15:8];
    bun.data[2] = word[7:0];
    bun.nbytes  = nb;
    bun.eom     = s_eom_r;
    bun.status  = s_eom_r ? err_nxt : ST_OK;
    bun.length  = (s_eom_r && err_nxt == ST_OK) ? len_ext[15:0] : 16'd0;

    produce   = (nb != 2'd0) || s_eom_r;
    bun_valid = s_valid_r && produce;
    advance   = s_valid_r && (!produce || bun_ready);
    in_ready  = !s_valid_r || advance;

    s_valid_nxt = in_valid ? 1'b1 : (s_valid_r && !advance);
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_char_r <= in_char;
      s_eom_r  <= in_eom;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      acc_r     <= '0;
      pos_r     <= '0;
      pad_r     <= '0;
      err_r     <= ST_OK;
      cnt_r     <= '0;
    end else begin
      if (in_ready) s_valid_r <= s_valid_nxt;
      if (advance) begin
        if (s_eom_r) begin
          acc_r <= '0;
          pos_r <= '0;
          pad_r <= '0;
          err_r <= ST_OK;
          cnt_r <= '0;
        end else begin
          acc_r <= acc_nxt;
          pos_r <= pos_nxt;
          pad_r <= pad_nxt;
          err_r <= err_nxt;
          cnt_r <= cnt_nxt;
        end
      end
    end
  end

endmodule

>>> rtl/sbd_out_queue.sv
module sbd_out_queue
  import sbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        bun_valid,
  output logic        bun_ready,
  input  sbd_bundle_t bun,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data_byte,
  output logic        byte_valid,
  output logic        run_last,
  output logic        message_done,
  output logic [1:0]  status,
  output logic [15:0] decoded_length
);

  sbd_bundle_t mem_r [2];
  logic        wr_r, rd_r;
  logic [1:0]  count_r, count_nxt;
  logic [1:0]  idx_r;
  sbd_bundle_t head;
  logic [1:0]  nres;
  logic        push, pop, bundle_end;

  assign bun_ready = (count_r != 2'd2);
  assign push      = bun_valid && bun_ready;
  assign head      = mem_r[rd_r];
  assign out_valid = (count_r != 2'd0);
  assign pop       = out_valid && out_ready;

  always_comb begin
    nres       = (head.nbytes == 2'd0) ? 2'd1 : head.nbytes;
    bundle_end = (idx_r == nres - 2'd1);
    byte_valid = (head.nbytes != 2'd0);
    case (idx_r)
      2'd0:    data_byte = head.data[0];
      2'd1:    data_byte = head.data[1];
      2'd2:    data_byte = head.data[2];
      default: data_byte = 8'd0;
    endcase
    if (!byte_valid) data_byte = 8'd0;
    run_last       = bundle_end;
    message_done   = bundle_end && head.eom;
    status         = message_done ? head.status : ST_OK;
    decoded_length = message_done ? head.length : 16'd0;
    count_nxt      = count_r + {1'b0, push} - {1'b0, pop && bundle_end};
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= bun;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= 1'b0;
      rd_r    <= 1'b0;
      count_r <= 2'd0;
      idx_r   <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_r <= !wr_r;
      if (pop) begin
        if (bundle_end) begin
          idx_r <= 2'd0;
          rd_r  <= !rd_r;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end
    end
  end

endmodule

>>> rtl/strict_base64_decoder_unit.sv
// Strict base64 decoder, one encoded character per input beat.
// Input: in_tdata carries the character, in_tlast marks the last character
// of a message. Output: one beat per decoded byte; a group of four
// characters yields up to three beats. out_tlast closes the beats caused by
// one input beat; out_tuser flags byte_valid, message_done and status.
// The last beat of a message carries status and decoded length; when no
// byte comes with it, a beat with byte_valid low carries them alone.
// On a nonzero status the receiver drops the bytes already seen.
// Each result passes through the input register and a group queue entry.
// Throughput: one input beat per cycle; the output drains one beat per
// cycle from a two-entry group queue, so a full queue stalls the input.
// cfg_valid/cfg_data write out_capacity (reset 65535); write only when idle.
// Reset (synchronous, rst_n low) clears the message state and the queue.
// When the receiver stalls, results wait in the queue and in_tready drops
// once both entries and the input register are occupied.
module strict_base64_decoder_unit
  import sbd_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] data_byte, [23:8] decoded_length
  output logic        out_tlast,  // run_last
  output logic [3:0]  out_tuser   // [0] byte_valid, [1] message_done, [3:2] status
);

  logic [15:0] cap_r;
  logic        bun_valid, bun_ready;
  sbd_bundle_t bun;
  logic [7:0]  data_byte;
  logic        byte_valid, message_done;
  logic [1:0]  status;
  logic [15:0] decoded_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 16'hffff;
    end else if (cfg_valid) begin
      cap_r <= cfg_data;
    end
  end

  sbd_decode #(.LENGTH_BITS(LENGTH_BITS)) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_char   (in_tdata),
    .in_eom    (in_tlast),
    .capacity  (cap_r),
    .bun_valid (bun_valid),
    .bun_ready (bun_ready),
    .bun       (bun)
  );

  sbd_out_queue u_queue (
    .clk            (clk),
    .rst_n          (rst_n),
    .bun_valid      (bun_valid),
    .bun_ready      (bun_ready),
    .bun            (bun),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .data_byte      (data_byte),
    .byte_valid     (byte_valid),
    .run_last       (out_tlast),
    .message_done   (message_done),
    .status         (status),
    .decoded_length (decoded_length)
  );

  assign out_tdata = {decoded_length, data_byte};
  assign out_tuser = {status, message_done, byte_valid};

endmodule

>>> tb/base64_decode_checker.sv
`timescale 1ns / 1ps

module base64_decode_checker
  import sbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // end_of_message
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [7:0] data_byte, [23:8] decoded_length
  input  logic        out_tlast,  // run_last
  input  logic [3:0]  out_tuser,  // [0] byte_valid, [1] message_done, [3:2] status
  output int          mismatch_count,
  output int          outstanding
);

  typedef struct packed {
    logic [7:0]  data;
    logic        data_valid;
    logic        run_last;
    logic        msg_done;
    logic [1:0]  status;
    logic [15:0] length;
  } result_beat_t;

  result_beat_t expected_beats[$];

  logic [15:0] capacity;
  logic [17:0] sextets;
  logic [1:0]  group_pos;
  logic [1:0]  pads_seen;
  logic [1:0]  msg_status;
  logic [15:0] bytes_out;

  initial begin
    mismatch_count = 0;
    outstanding = 0;
  end

  task automatic flag_mismatch(input string what);
    if (mismatch_count < 40) $display("%0t: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Sextet value of an alphabet character; the pad and the foreign classes
  // lie above 63.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return 7'(c - "A");
    if (c >= "a" && c <= "z") return 7'(c - "a" + 8'd26);
    if (c >= "0" && c <= "9") return 7'(c - "0" + 8'd52);
    if (c == "+") return 7'd62;
    if (c == "/") return 7'd63;
    if (c == "=") return CH_PAD;
    return CH_BAD;
  endfunction

  task automatic clear_message();
    sextets    = '0;
    group_pos  = '0;
    pads_seen  = '0;
    msg_status = ST_OK;
    bytes_out  = '0;
  endtask

  task automatic decode_char(input logic [7:0] c, input logic eom);
    logic [6:0]   v;
    logic [23:0]  word;
    logic [1:0]   n;
    int           nbytes;
    int           i;
    result_beat_t r;
    v = sextet_of(c);
    nbytes = 0;
    if (v == CH_PAD) begin
      if (group_pos == 2'd2 && pads_seen == 2'd0 && !eom) begin
        pads_seen = 2'd1;
      end else if (group_pos == 2'd3 && eom && pads_seen < 2'd2) begin
        pads_seen = pads_seen + 2'd1;
      end else begin
        msg_status = ST_MALFORMED;
      end
      v = 7'd0;
    end else if (v == CH_BAD) begin
      msg_status = ST_MALFORMED;
      v = 7'd0;
    end else if (pads_seen != 2'd0) begin
      msg_status = ST_MALFORMED;
    end
    // Length and dropped-bit rules can only be judged on the final character.
    if (eom) begin
      if (group_pos != 2'd3) msg_status = ST_MALFORMED;
      if (pads_seen == 2'd1 && sextets[1:0] != 2'b00) msg_status = ST_MALFORMED;
      if (pads_seen == 2'd2 && sextets[9:6] != 4'h0) msg_status = ST_MALFORMED;
    end
    word = {sextets, v[5:0]};
    if (group_pos == 2'd3 && msg_status == ST_OK) begin
      n = 2'd3 - pads_seen;
      if (17'(bytes_out) + 17'(n) > 17'(capacity)) begin
        msg_status = ST_CAPACITY;
      end else begin
        nbytes = n;
        bytes_out = bytes_out + 16'(n);
      end
    end
    sextets = (group_pos == 2'd3) ? 18'd0 : word[17:0];
    group_pos = group_pos + 2'd1;
    for (i = 0; i < nbytes; i++) begin
      r = '0;
      r.data = word[23 - 8 * i -: 8];
      r.data_valid = 1'b1;
      r.run_last = (i == nbytes - 1);
      r.msg_done = r.run_last && eom;
      if (r.msg_done) begin
        r.status = msg_status;
        r.length = bytes_out;
      end
      expected_beats.push_back(r);
    end
    // A message that ends without a byte still closes with a status beat.
    if (eom && nbytes == 0) begin
      r = '0;
      r.run_last = 1'b1;
      r.msg_done = 1'b1;
      r.status = msg_status;
      r.length = (msg_status == ST_OK) ? bytes_out : 16'd0;
      expected_beats.push_back(r);
    end
    if (eom) clear_message();
  endtask

  task automatic compare_beat(input result_beat_t want);
    if (out_tdata[7:0] !== want.data)
      flag_mismatch($sformatf("data_byte %02h, predicted %02h", out_tdata[7:0], want.data));
    if (out_tdata[23:8] !== want.length)
      flag_mismatch($sformatf("decoded_length %0d, predicted %0d",
                              out_tdata[23:8], want.length));
    if (out_tlast !== want.run_last)
      flag_mismatch($sformatf("run_last %b, predicted %b", out_tlast, want.run_last));
    if (out_tuser[0] !== want.data_valid)
      flag_mismatch($sformatf("byte_valid %b, predicted %b", out_tuser[0], want.data_valid));
    if (out_tuser[1] !== want.msg_done)
      flag_mismatch($sformatf("message_done %b, predicted %b", out_tuser[1], want.msg_done));
    if (out_tuser[3:2] !== want.status)
      flag_mismatch($sformatf("status %0d, predicted %0d", out_tuser[3:2], want.status));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      capacity = 16'hFFFF;
      clear_message();
      expected_beats.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) capacity = cfg_data;
      if (out_tvalid && out_tready) begin
        if (expected_beats.size() == 0) begin
          flag_mismatch("result beat with no decoded result pending");
        end else begin
          compare_beat(expected_beats.pop_front());
        end
      end
      if (in_tvalid && in_tready) decode_char(in_tdata, in_tlast);
      outstanding <= expected_beats.size();
    end
  end

endmodule

>>> tb/tb_strict_base64_decoder_unit.sv
`timescale 1ns / 1ps

module tb_strict_base64_decoder_unit;

  localparam int SETTLE_CYCLES  = 8;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int RANDOM_CHARS   = 60;
  localparam int PHASES         = 6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;   // [7:0] char_code
  logic        in_tlast = 1'b0;   // end_of_message
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [7:0] data_byte, [23:8] decoded_length
  logic        out_tlast;         // run_last
  logic [3:0]  out_tuser;         // [0] byte_valid, [1] message_done, [3:2] status

  int         mismatch_count;
  int         outstanding;
  bit         tx_calm = 1'b0;
  bit         rx_hold_req = 1'b0;
  int         random_sent = 0;
  logic [7:0] msg_chars[$];

  strict_base64_decoder_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  base64_decode_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .out_tuser      (out_tuser),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("** strict_base64_decoder_unit: FAILED **");
    $finish;
  end

  // Result side: a random stall before each beat, calm stretches without
  // stalls, and one long hold when the stimulus asks for it.
  initial begin : receiver
    int gap;
    int beats;
    bit calm;
    beats = 0;
    calm = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_req) begin
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      if (beats % 16 == 0) calm = ($urandom_range(0, 2) == 0);
      gap = calm ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      beats++;
    end
  end

  function automatic logic [7:0] to_b64(input logic [5:0] v);
    if (v < 6'd26) return 8'("A" + v);
    if (v < 6'd52) return 8'("a" + v - 6'd26);
    if (v < 6'd62) return 8'("0" + v - 6'd52);
    if (v == 6'd62) return "+";
    return "/";
  endfunction

  // Valid stays up after the last beat so that back-to-back characters
  // follow without a gap; wait_idle lowers it.
  task automatic send_char(input logic [7:0] c, input logic eom);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= eom;
    do @(posedge clk); while (!(in_tvalid && in_tready));
  endtask

  task automatic send_message();
    int i;
    for (i = 0; i < msg_chars.size(); i++) send_char(msg_chars[i], i == msg_chars.size() - 1);
  endtask

  task automatic send_text(input string s);
    int i;
    msg_chars.delete();
    for (i = 0; i < s.len(); i++) msg_chars.push_back(s[i]);
    send_message();
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  task automatic gen_well_formed(input int groups);
    int n;
    msg_chars.delete();
    repeat (4 * groups) msg_chars.push_back(to_b64(6'($urandom)));
    n = msg_chars.size();
    // The bits that the padding drops are cleared so the message stays legal.
    case ($urandom_range(0, 2))
      1: begin
        msg_chars[n - 2] = to_b64(6'($urandom_range(0, 15) << 2));
        msg_chars[n - 1] = "=";
      end
      2: begin
        msg_chars[n - 3] = to_b64(6'($urandom_range(0, 3) << 4));
        msg_chars[n - 2] = "=";
        msg_chars[n - 1] = "=";
      end
      default: ;
    endcase
  endtask

  task automatic random_message();
    int groups;
    int n;
    int pos;
    groups = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 3);
    gen_well_formed(groups);
    n = msg_chars.size();
    pos = $urandom_range(0, n - 1);
    case ($urandom_range(0, 15))
      0, 1: msg_chars[pos] = 8'($urandom_range(0, 255));
      2: begin
        repeat ($urandom_range(1, 3)) msg_chars.delete(msg_chars.size() - 1);
      end
      3: msg_chars.insert(pos, "=");
      4: msg_chars.push_back(to_b64(6'($urandom)));
      5: begin
        // Random bits under the padding, usually nonzero.
        if (msg_chars[n - 1] == "=") begin
          if (msg_chars[n - 2] == "=") msg_chars[n - 3] = to_b64(6'($urandom));
          else msg_chars[n - 2] = to_b64(6'($urandom));
        end
      end
      default: ;
    endcase
    tx_calm = ($urandom_range(0, 2) == 0);
    send_message();
    random_sent += msg_chars.size();
  endtask

  initial begin : stimulus
    logic [15:0] cap;
    int          ph;
    int          phase_start;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("Az+/Za09");
    send_text("TQ==");
    send_text("TWE=");
    send_text("TWF=");       // one pad, but the dropped bits are not zero
    send_text("TW=A");       // alphabet character after a pad
    send_char(8'hFF, 1'b0);  // foreign characters, and a message too short
    send_char(8'h00, 1'b1);

    write_capacity(16'd3);
    send_text("TWFu");
    send_text("TWFuTWFu");
    write_capacity(16'd0);
    send_text("TQ==");
    send_text("TWFuT$Fu");   // capacity first, then a malformed finding

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph % 3)
        0: cap = 16'($urandom_range(0, 15));
        1: cap = 16'hFFFF;
        default: cap = 16'($urandom_range(0, 65535));
      endcase
      write_capacity(cap);
      phase_start = random_sent;
      while (random_sent - phase_start < RANDOM_CHARS / PHASES) random_message();
    end

    // Long message against a held-off receiver so the block backs up.
    write_capacity(16'hFFFF);
    rx_hold_req = 1'b1;
    tx_calm = 1'b1;
    gen_well_formed(8);
    send_message();

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("** strict_base64_decoder_unit: PASSED **");
    end else begin
      $display("** strict_base64_decoder_unit: FAILED **");
    end
    $finish;
  end

endmodule
